// ===== rtl/twl_pkg.sv =====
// twl_pkg: shared codes and the result item type of the two-wire handshake link.
// No dependencies; imported by every other file of the block.
package twl_pkg;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_GAP = 1'b1;

  localparam logic [31:0] TIMEOUT_RESET = 32'd1000000;
  localparam logic [15:0] BIT_GAP_RESET = 16'd0;

  // Command codes; the unused code acts as a plain tick
  localparam logic [1:0] CMD_NONE = 2'd0;
  localparam logic [1:0] CMD_SEND = 2'd1;
  localparam logic [1:0] CMD_RECV = 2'd2;

  // Completion status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SEND_TO = 2'd1;
  localparam logic [1:0] ST_RECV_TO = 2'd2;

  typedef struct packed {
    logic       red_release;
    logic       white_release;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] received_byte;
    logic       line_active;
  } res_t;

endpackage

// ===== rtl/twl_core.sv =====
// twl_core: per-tick protocol sequencer, configuration registers and timers.
// Depends on twl_pkg; produces one result item per accepted tick.
module twl_core #(
  parameter int unsigned BITS_PER_WORD = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [twl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [twl_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                         step_i,
  input  logic [1:0]                   cmd_i,
  input  logic [7:0]                   send_byte_i,
  input  logic                         red_line_i,
  input  logic                         white_line_i,
  output twl_pkg::res_t                res_o
);
  import twl_pkg::*;

  localparam int unsigned CntW = $clog2(BITS_PER_WORD + 1);
  localparam logic [CntW-1:0] LastCnt = CntW'(BITS_PER_WORD);

  typedef enum logic [3:0] {
    PH_IDLE, PH_S_ACK, PH_S_REL, PH_S_GAP, PH_R_BIT, PH_R_ACK, PH_R_GAP
  } phase_e;

  phase_e         phase_q, phase_d;
  logic [7:0]     shift_q, shift_d;
  logic [CntW-1:0] bit_cnt_q, bit_cnt_d;
  logic [31:0]    wait_q, wait_d;
  logic [15:0]    gap_q, gap_d;
  logic           cur_bit_q, cur_bit_d;
  logic [31:0]    timeout_q;
  logic [15:0]    bit_gap_q;

  logic        bit_done, not_met, gap_end, adv, sending;
  logic [31:0] wait_inc;
  logic        done;
  logic [1:0]  status;
  logic [7:0]  rbyte;

  always_comb begin
    phase_d   = phase_q;
    shift_d   = shift_q;
    bit_cnt_d = bit_cnt_q;
    wait_d    = wait_q;
    gap_d     = gap_q;
    cur_bit_d = cur_bit_q;
    bit_done  = 1'b0;
    not_met   = 1'b0;
    gap_end   = 1'b0;
    adv       = 1'b0;
    sending   = 1'b0;
    done      = 1'b0;
    status    = ST_OK;
    rbyte     = 8'd0;
    wait_inc  = wait_q + 32'd1;

    unique case (phase_q)
      PH_IDLE: begin
        if (cmd_i == CMD_SEND) begin
          shift_d   = send_byte_i;
          bit_cnt_d = '0;
          wait_d    = '0;
          cur_bit_d = send_byte_i[0];
          phase_d   = PH_S_ACK;
        end else if (cmd_i == CMD_RECV) begin
          shift_d   = '0;
          bit_cnt_d = '0;
          wait_d    = '0;
          phase_d   = PH_R_BIT;
        end
      end
      PH_S_ACK: begin
        sending = 1'b1;
        if ((cur_bit_q ? red_line_i : white_line_i) == 1'b0) begin
          wait_d  = '0;
          phase_d = PH_S_REL;
        end else begin
          not_met = 1'b1;
        end
      end
      PH_S_REL: begin
        sending = 1'b1;
        if ((cur_bit_q ? red_line_i : white_line_i) == 1'b1) begin
          shift_d  = {1'b0, shift_q[7:1]};
          bit_done = 1'b1;
        end else begin
          not_met = 1'b1;
        end
      end
      PH_R_BIT: begin
        if (red_line_i && white_line_i) begin
          not_met = 1'b1;
        end else begin
          // white low alone is a one, every other low pattern a zero
          cur_bit_d = red_line_i & ~white_line_i;
          shift_d   = {red_line_i & ~white_line_i, shift_q[7:1]};
          wait_d    = '0;
          phase_d   = PH_R_ACK;
        end
      end
      PH_R_ACK: begin
        if ((cur_bit_q ? white_line_i : red_line_i) == 1'b1) bit_done = 1'b1;
        else                                                  not_met  = 1'b1;
      end
      PH_S_GAP, PH_R_GAP: begin
        sending = (phase_q == PH_S_GAP);
        if (gap_q != 16'd0) gap_d = gap_q - 16'd1;
        if (gap_d == 16'd0) gap_end = 1'b1;
      end
      default: begin
        phase_d   = PH_IDLE;
        bit_cnt_d = '0;
      end
    endcase

    if (bit_done) begin
      bit_cnt_d = bit_cnt_q + CntW'(1);
      if (bit_gap_q != 16'd0) begin
        gap_d   = bit_gap_q;
        phase_d = sending ? PH_S_GAP : PH_R_GAP;
      end else begin
        adv = 1'b1;
      end
    end
    if (gap_end) adv = 1'b1;

    if (adv) begin
      if (bit_cnt_d >= LastCnt) begin
        done      = 1'b1;
        status    = ST_OK;
        rbyte     = sending ? 8'd0 : shift_d;
        phase_d   = PH_IDLE;
        bit_cnt_d = '0;
      end else begin
        wait_d = '0;
        if (sending) begin
          cur_bit_d = shift_d[0];
          phase_d   = PH_S_ACK;
        end else begin
          phase_d = PH_R_BIT;
        end
      end
    end

    // a zero timeout trips on the first miss, like a timeout of one
    if (not_met) begin
      wait_d = wait_inc;
      if (wait_inc >= timeout_q) begin
        done      = 1'b1;
        status    = sending ? ST_SEND_TO : ST_RECV_TO;
        phase_d   = PH_IDLE;
        bit_cnt_d = '0;
        wait_d    = '0;
      end
    end
  end

  always_comb begin
    res_o.red_release   = 1'b1;
    res_o.white_release = 1'b1;
    if (phase_d == PH_S_ACK) begin
      if (cur_bit_d) res_o.white_release = 1'b0;
      else           res_o.red_release   = 1'b0;
    end else if (phase_d == PH_R_ACK) begin
      if (cur_bit_d) res_o.red_release   = 1'b0;
      else           res_o.white_release = 1'b0;
    end
    res_o.busy_res      = (phase_d != PH_IDLE);
    res_o.done_res      = done;
    res_o.status        = status;
    res_o.received_byte = rbyte;
    res_o.line_active   = (phase_d == PH_IDLE) && (!red_line_i || !white_line_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      shift_q   <= '0;
      bit_cnt_q <= '0;
      wait_q    <= '0;
      gap_q     <= '0;
      cur_bit_q <= 1'b0;
      timeout_q <= TIMEOUT_RESET;
      bit_gap_q <= BIT_GAP_RESET;
    end else begin
      if (step_i) begin
        phase_q   <= phase_d;
        shift_q   <= shift_d;
        bit_cnt_q <= bit_cnt_d;
        wait_q    <= wait_d;
        gap_q     <= gap_d;
        cur_bit_q <= cur_bit_d;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_TIMEOUT: timeout_q <= cfg_data_i;
          CFG_BIT_GAP: bit_gap_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
    end
  end

  a_idle_cnt_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> bit_cnt_q == '0)
    else $error("bit counter not cleared while idle");

  a_busy_not_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i |-> !(res_o.busy_res && res_o.line_active))
    else $error("line activity flagged during a transfer");

  a_fail_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.done_res && res_o.status != ST_OK |->
      res_o.received_byte == 8'd0 && !res_o.busy_res)
    else $error("aborted transfer left data or busy flag");

endmodule

// ===== rtl/twl_out_buf.sv =====
// twl_out_buf: output register plus one skid entry for result items.
// Depends on twl_pkg for the result item type.
module twl_out_buf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  twl_pkg::res_t res_i,
  output logic          full_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output twl_pkg::res_t res_o
);
  import twl_pkg::*;

  logic out_valid_q, skid_valid_q;
  res_t out_q, skid_q;
  logic pop;

  assign pop         = out_valid_q && !out_stall_i;
  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!out_valid_q || pop) begin
        out_valid_q  <= skid_valid_q || push_i;
        skid_valid_q <= 1'b0;
      end else if (push_i) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop) begin
      out_q <= skid_valid_q ? skid_q : res_i;
    end else if (push_i) begin
      skid_q <= res_i;
    end
  end

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held with empty output register");

  a_stall_fills_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i && push_i |=> skid_valid_q)
    else $error("item pushed under stall was dropped");

  a_drain_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !push_i && !skid_valid_q |=> !out_valid_q)
    else $error("result item repeated after drain");

endmodule

// ===== rtl/two_wire_handshake_link.sv =====
// two_wire_handshake_link: top level of the two-wire handshake link controller.
// Depends on twl_pkg, twl_core and twl_out_buf.
//
// Usage
//   Each input item is one tick of the link: a command (plain tick, send a
//   byte, receive a byte) plus the sampled red and white wire levels. Each
//   accepted item yields exactly one result item: the wire drives (1 means
//   released), busy, a done pulse with status, the received byte and an
//   idle line-activity flag. Bits move LSB first.
//   Input channel:  in_valid_i / in_stall_o, item taken when valid and not
//   stalled. Output channel: out_valid_o / out_stall_i, same rule.
//   The sequencer works combinationally between the input fields and the
//   output register. Throughput is one item per cycle while in_stall_o is
//   low; the next-state logic (one 32-bit timer increment and compare) sets it.
//   A receiver stall first parks one result in a skid entry, so one more
//   item is taken; only with both entries full does in_stall_o rise.
//   Reset returns to idle, clears timers and sets timeout_ticks to 1000000
//   and bit_gap_ticks to 0. Configuration writes (cfg_we_i, cfg_idx_i,
//   cfg_data_i) take effect at once; index 0 is timeout, 1 is bit gap.
module two_wire_handshake_link #(
  parameter int unsigned BITS_PER_WORD = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [twl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [twl_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     cmd_i,
  input  logic [7:0]                     send_byte_i,
  input  logic                           red_line_i,
  input  logic                           white_line_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           red_release_o,
  output logic                           white_release_o,
  output logic                           busy_res_o,
  output logic                           done_res_o,
  output logic [1:0]                     status_o,
  output logic [7:0]                     received_byte_o,
  output logic                           line_active_o
);
  import twl_pkg::*;

  logic full;
  logic step;
  res_t core_res, out_res;

  // an item is taken whenever the skid entry is free
  assign in_stall_o = full;
  assign step       = in_valid_i && !full;

  twl_core #(
    .BITS_PER_WORD(BITS_PER_WORD)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .step_i      (step),
    .cmd_i       (cmd_i),
    .send_byte_i (send_byte_i),
    .red_line_i  (red_line_i),
    .white_line_i(white_line_i),
    .res_o       (core_res)
  );

  twl_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (step),
    .res_i      (core_res),
    .full_o     (full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .res_o      (out_res)
  );

  assign red_release_o   = out_res.red_release;
  assign white_release_o = out_res.white_release;
  assign busy_res_o      = out_res.busy_res;
  assign done_res_o      = out_res.done_res;
  assign status_o        = out_res.status;
  assign received_byte_o = out_res.received_byte;
  assign line_active_o   = out_res.line_active;

endmodule

// ===== tb/sv/two_wire_handshake_link_test.sv =====
// two_wire_handshake_link_test: self-checking bench for the two-wire handshake link.
// Random line traffic with a tick-level predictor and in-order result checking.
// Depends on twl_pkg and two_wire_handshake_link.
module two_wire_handshake_link_test;
  timeunit 1ns;
  timeprecision 1ps;

  import twl_pkg::*;

  localparam int unsigned WORD_BITS = 8;

  // Controller phases as the predictor tracks them
  typedef enum logic [3:0] {
    LK_IDLE,
    LK_SEND_ACK,
    LK_SEND_REL,
    LK_SEND_GAP,
    LK_RECV_BIT,
    LK_RECV_ACK,
    LK_RECV_GAP
  } link_phase_e;

  // One input item: a single tick of the link
  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] send_byte;
    logic       red;
    logic       white;
  } tick_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT hookup. Every input has a known value from time zero.
  // ---------------------------------------------------------------------------
  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = CFG_TIMEOUT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           cmd = CMD_NONE;
  logic [7:0]           send_byte = 8'h00;
  logic                 red_line = 1'b1;
  logic                 white_line = 1'b1;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 red_release;
  logic                 white_release;
  logic                 busy_res;
  logic                 done_res;
  logic [1:0]           status;
  logic [7:0]           received_byte;
  logic                 line_active;

  always #2 clk_i = ~clk_i;

  two_wire_handshake_link u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .cmd_i           (cmd),
    .send_byte_i     (send_byte),
    .red_line_i      (red_line),
    .white_line_i    (white_line),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .red_release_o   (red_release),
    .white_release_o (white_release),
    .busy_res_o      (busy_res),
    .done_res_o      (done_res),
    .status_o        (status),
    .received_byte_o (received_byte),
    .line_active_o   (line_active)
  );

  // ---------------------------------------------------------------------------
  // Shared bench state
  // ---------------------------------------------------------------------------
  tick_t       pending_ticks[$];  // items still to be offered
  res_t        expected_res[$];   // predicted results, oldest first
  tick_t       cur_tick;          // item currently on the input bus
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int          errors = 0;

  // ---------------------------------------------------------------------------
  // Link predictor: its own copy of the controller state and registers.
  // Registers only change while nothing is in flight, so updating the copy
  // at the write edge is safe.
  // ---------------------------------------------------------------------------
  link_phase_e lk_phase = LK_IDLE;
  logic [7:0]  lk_shift = '0;
  logic [3:0]  lk_bits = '0;
  logic [31:0] lk_wait = '0;
  logic [15:0] lk_gap = '0;
  logic        lk_bit = 1'b0;
  logic [31:0] timeout_ticks = TIMEOUT_RESET;
  logic [15:0] bit_gap_ticks = BIT_GAP_RESET;
  res_t        lk_res;

  // Start the next bit, or finish the byte once all bits have moved
  function automatic void next_bit(input logic sending);
    if (lk_bits >= WORD_BITS) begin
      lk_res.done_res = 1'b1;
      lk_res.status = ST_OK;
      if (!sending) lk_res.received_byte = lk_shift;
      lk_phase = LK_IDLE;
      lk_bits = '0;
    end else begin
      lk_wait = '0;
      if (sending) begin
        lk_bit = lk_shift[0];
        lk_phase = LK_SEND_ACK;
      end else begin
        lk_phase = LK_RECV_BIT;
      end
    end
  endfunction

  // A bit is through; either sit out the gap or go straight on
  function automatic void bit_done(input logic sending);
    lk_bits = lk_bits + 1'b1;
    if (bit_gap_ticks != 16'd0) begin
      lk_gap = bit_gap_ticks;
      lk_phase = sending ? LK_SEND_GAP : LK_RECV_GAP;
    end else begin
      next_bit(sending);
    end
  endfunction

  // Partner did not answer this tick; abort when the wait runs out.
  // A zero timeout aborts on the first miss, same as one.
  function automatic void wait_missed(input logic sending);
    lk_wait = lk_wait + 32'd1;
    if (lk_wait >= timeout_ticks) begin
      lk_res.done_res = 1'b1;
      lk_res.status = sending ? ST_SEND_TO : ST_RECV_TO;
      lk_phase = LK_IDLE;
      lk_bits = '0;
      lk_wait = '0;
    end
  endfunction

  function automatic res_t link_tick(input tick_t t);
    lk_res = '0;
    case (lk_phase)
      // Commands only count here; the unused code falls through as a plain tick.
      // Lines on the start tick are not looked at.
      LK_IDLE: begin
        if (t.cmd == CMD_SEND) begin
          lk_shift = t.send_byte;
          lk_bits = '0;
          lk_wait = '0;
          lk_bit = t.send_byte[0];
          lk_phase = LK_SEND_ACK;
        end else if (t.cmd == CMD_RECV) begin
          lk_shift = '0;
          lk_bits = '0;
          lk_wait = '0;
          lk_phase = LK_RECV_BIT;
        end
      end
      LK_SEND_ACK: begin
        if ((lk_bit ? t.red : t.white) == 1'b0) begin
          lk_wait = '0;
          lk_phase = LK_SEND_REL;
        end else begin
          wait_missed(1'b1);
        end
      end
      LK_SEND_REL: begin
        if ((lk_bit ? t.red : t.white) == 1'b1) begin
          lk_shift = lk_shift >> 1;
          bit_done(1'b1);
        end else begin
          wait_missed(1'b1);
        end
      end
      // White low alone is a one; any other low pattern is a zero
      LK_RECV_BIT: begin
        if (t.red && t.white) begin
          wait_missed(1'b0);
        end else begin
          lk_bit = t.red && !t.white;
          lk_shift = {lk_bit, lk_shift[7:1]};
          lk_wait = '0;
          lk_phase = LK_RECV_ACK;
        end
      end
      LK_RECV_ACK: begin
        if ((lk_bit ? t.white : t.red) == 1'b1) bit_done(1'b0);
        else wait_missed(1'b0);
      end
      LK_SEND_GAP, LK_RECV_GAP: begin
        if (lk_gap != 16'd0) lk_gap = lk_gap - 16'd1;
        if (lk_gap == 16'd0) next_bit(lk_phase == LK_SEND_GAP);
      end
      default: begin
        lk_phase = LK_IDLE;
        lk_bits = '0;
      end
    endcase

    // Drives reflect the phase after this tick
    lk_res.red_release = !((lk_phase == LK_SEND_ACK && !lk_bit) ||
                           (lk_phase == LK_RECV_ACK && lk_bit));
    lk_res.white_release = !((lk_phase == LK_SEND_ACK && lk_bit) ||
                             (lk_phase == LK_RECV_ACK && !lk_bit));
    lk_res.busy_res = (lk_phase != LK_IDLE);
    lk_res.line_active = (lk_phase == LK_IDLE) && (!t.red || !t.white);
    return lk_res;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers queued items, predicts each one as it is taken.
  // Payload only moves when the bus is free or the item just went through.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_res.push_back(link_tick(cur_tick));
      if (!in_valid || !in_stall) begin
        if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_tick = pending_ticks.pop_front();
          in_valid <= 1'b1;
          cmd <= cur_tick.cmd;
          send_byte <= cur_tick.send_byte;
          red_line <= cur_tick.red;
          white_line <= cur_tick.white;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random stalls on the result side, field-wise compare on accept
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_res.size() == 0) begin
          $error("result item with nothing expected");
          errors++;
        end else begin
          want = expected_res.pop_front();
          check_field("red_release", 8'(want.red_release), 8'(red_release));
          check_field("white_release", 8'(want.white_release), 8'(white_release));
          check_field("busy_res", 8'(want.busy_res), 8'(busy_res));
          check_field("done_res", 8'(want.done_res), 8'(done_res));
          check_field("status", 8'(want.status), 8'(status));
          check_field("received_byte", want.received_byte, received_byte);
          check_field("line_active", 8'(want.line_active), 8'(line_active));
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void push_tick(input logic [1:0] c, input logic [7:0] b,
                                    input logic r, input logic w);
    tick_t t;
    t.cmd = c;
    t.send_byte = b;
    t.red = r;
    t.white = w;
    pending_ticks.push_back(t);
  endfunction

  // Nothing queued, nothing on the bus, nothing outstanding
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_ticks.size() != 0 || in_valid || expected_res.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CFG_TIMEOUT) timeout_ticks = val;
    else bit_gap_ticks = val[15:0];
    @(negedge clk_i);
  endtask

  // Mostly whole transfers with a random partner on the lines. Stuck
  // stretches (both lines held) provoke timeouts; short noise bursts carry
  // any command code; now and then the sender holds off until all is back.
  task automatic gen_traffic(input int unsigned n_ticks);
    int unsigned pushed;
    int unsigned span;
    int unsigned kind;
    int unsigned stuck_left;
    int unsigned gap_eff;
    logic        stuck_lvl;
    logic [1:0]  c;
    pushed = 0;
    stuck_left = 0;
    stuck_lvl = 1'b1;
    gap_eff = (bit_gap_ticks > 16'd8) ? 8 : bit_gap_ticks;
    while (pushed < n_ticks) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        push_tick((kind < 35) ? CMD_SEND : CMD_RECV, 8'($urandom),
                  1'($urandom_range(1)), 1'($urandom_range(1)));
        span = 8 * (gap_eff + 5) + $urandom_range(8);
        repeat (span) begin
          c = ($urandom_range(9) == 0) ? 2'($urandom_range(3)) : CMD_NONE;
          if (stuck_left == 0 && $urandom_range(24) == 0) begin
            stuck_left = $urandom_range(2, 10);
            stuck_lvl = 1'($urandom_range(1));
          end
          if (stuck_left != 0) begin
            push_tick(c, 8'($urandom), stuck_lvl, stuck_lvl);
            stuck_left--;
          end else begin
            push_tick(c, 8'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)));
          end
        end
        pushed += span + 1;
      end else if (kind < 95) begin
        span = $urandom_range(1, 6);
        repeat (span)
          push_tick(2'($urandom_range(3)), 8'($urandom),
                    1'($urandom_range(1)), 1'($urandom_range(1)));
        pushed += span;
      end else begin
        wait_drained();
      end
    end
  endtask

  task automatic run_phase(input int unsigned s_pct, input int unsigned r_pct,
                           input logic [31:0] tmo, input logic [15:0] gap,
                           input int unsigned n_ticks);
    wait_drained();
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    write_reg(CFG_TIMEOUT, tmo);
    write_reg(CFG_BIT_GAP, {16'd0, gap});
    gen_traffic(n_ticks);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = 19;
    recv_idle_pct = 82;
    write_reg(CFG_TIMEOUT, 32'd2);

    // Directed: idle line activity, unused command, one good send bit then a
    // send abort, command while busy and on the finishing tick, a receive of
    // a one and a zero then a receive abort, a zero bit sent then an abort.
    push_tick(CMD_NONE, 8'h00, 1'b0, 1'b1);
    push_tick(CMD_NONE, 8'h00, 1'b1, 1'b0);
    push_tick(CMD_NONE, 8'h00, 1'b0, 1'b0);
    push_tick(2'd3, 8'hFF, 1'b1, 1'b1);
    push_tick(CMD_SEND, 8'hFF, 1'b0, 1'b0);   // lines ignored on start
    push_tick(CMD_RECV, 8'h00, 1'b1, 1'b1);   // ignored while busy, one miss
    push_tick(CMD_NONE, 8'h00, 1'b0, 1'b1);   // red answers
    push_tick(CMD_NONE, 8'h00, 1'b1, 1'b1);   // red back, bit done
    push_tick(CMD_NONE, 8'h00, 1'b1, 1'b1);
    push_tick(CMD_RECV, 8'h00, 1'b1, 1'b1);   // send times out, cmd dropped
    push_tick(CMD_RECV, 8'h00, 1'b1, 1'b1);
    push_tick(CMD_NONE, 8'h00, 1'b1, 1'b0);   // white low alone: one
    push_tick(CMD_NONE, 8'h00, 1'b1, 1'b0);
    push_tick(CMD_NONE, 8'h00, 1'b1, 1'b1);
    push_tick(CMD_NONE, 8'h00, 1'b0, 1'b0);   // both low: zero
    push_tick(CMD_NONE, 8'h00, 1'b1, 1'b1);
    push_tick(CMD_NONE, 8'h00, 1'b1, 1'b1);
    push_tick(CMD_NONE, 8'h00, 1'b1, 1'b1);   // receive times out
    push_tick(CMD_SEND, 8'h00, 1'b1, 1'b1);
    push_tick(CMD_NONE, 8'h00, 1'b1, 1'b0);
    push_tick(CMD_NONE, 8'h00, 1'b0, 1'b1);
    push_tick(CMD_NONE, 8'h00, 1'b1, 1'b1);
    push_tick(CMD_NONE, 8'h00, 1'b1, 1'b1);

    // Sender idles lightly, receiver heavily
    run_phase(19, 82, 32'd2, 16'd0, 110);
    run_phase(19, 82, 32'd8, 16'd0, 120);
    run_phase(19, 82, 32'd8, 16'd3, 120);
    run_phase(19, 82, 32'd30, 16'd1, 100);

    // The other way round; zero timeout behaves as one
    run_phase(82, 19, 32'd0, 16'd0, 90);
    run_phase(82, 19, 32'd1, 16'd2, 90);
    run_phase(82, 19, 32'd12, 16'd0, 120);
    run_phase(82, 19, 32'hFFFF_FFFF, 16'd0, 120);

    // No idling
    run_phase(0, 0, 32'd8, 16'd0, 110);
    run_phase(0, 0, TIMEOUT_RESET, BIT_GAP_RESET, 80);

    // Longest gap setting: one send, then a short run of plain ticks; if the
    // first bit gets through, the run ends partway into the gap
    run_phase(0, 0, 32'd6, 16'hFFFF, 0);
    push_tick(CMD_SEND, 8'($urandom), 1'b1, 1'b1);
    repeat (60)
      push_tick(CMD_NONE, 8'h00, 1'($urandom_range(1)), 1'($urandom_range(1)));

    wait_drained();
    repeat (5) @(posedge clk_i);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/twl_pkg.sv
rtl/twl_core.sv
rtl/twl_out_buf.sv
rtl/two_wire_handshake_link.sv
tb/sv/two_wire_handshake_link_test.sv
